>>> hdl/urxf_pkg.sv
`timescale 1ns / 1ps

package urxf_pkg;

  // FIFO geometry; the depth is a power of two so pointers wrap naturally.
  localparam int FIFO_DEPTH = 256;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_PW    = FIFO_AW + 1;

  // Item kinds carried in the mode field.
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;
  localparam logic [1:0] MODE_LINE  = 2'd3;

  // Register addresses.
  localparam logic [2:0] ADDR_DATA   = 3'd3;
  localparam logic [2:0] ADDR_STATUS = 3'd5;

  // Status bit positions and other constants.
  localparam int         ST_TXRDY_BIT    = 0;
  localparam int         ST_RXRDY_BIT    = 2;
  localparam logic [7:0] READ_UNMAPPED   = 8'hff;
  localparam logic [15:0] CHAR_TIME_RESET = 16'd130;

  typedef logic [FIFO_PW-1:0] fifo_ptr_t;
  typedef logic [FIFO_AW-1:0] fifo_idx_t;

endpackage

>>> hdl/urxf_if.sv
`timescale 1ns / 1ps

// Input channel: one bus access, tick or received line byte per beat.
interface urxf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [2:0]  addr;
  logic [7:0]  data;
  logic [15:0] elapsed_us;

  modport source (output valid, mode, addr, data, elapsed_us, input ready);
  modport sink   (input valid, mode, addr, data, elapsed_us, output ready);
endinterface

// Result channel: one result beat per input beat.
interface urxf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq;
  logic       tx_valid;
  logic [7:0] tx_byte;

  modport source (output valid, read_data, irq, tx_valid, tx_byte, input ready);
  modport sink   (input valid, read_data, irq, tx_valid, tx_byte, output ready);
endinterface

>>> hdl/uart_registers_with_rx_fifo.sv
`timescale 1ns / 1ps

// UART register block with a 256-byte receive FIFO.
// in_ch carries one beat per event: a bus read or write (addr 3 data, addr 5
// status/mask), a time tick with elapsed microseconds, or a byte from the line.
// out_ch returns exactly one beat per input beat, in order: read data, the
// interrupt line after the event, and the byte sent when the event transmits.
// cfg_we/cfg_wdata load the character time in microseconds. The user must load
// it only while idle; the block does not enforce this. The read stage reads the
// FIFO memory at the read pointer; the execute stage then executes the event and
// loads the output register. Throughput is one beat per cycle while out_ch.ready
// is high, set by the single read and single write port of the FIFO memory; a
// byte written by one event and read by the next is forwarded around the memory.
// Reset (rst_n low, synchronous) sets TxRDY, clears the mask, timers, holding
// register and FIFO pointers, and loads a character time of 130. The FIFO
// memory itself is not cleared; only written entries are ever read.
// When the receiver holds out_ch.ready low, the result stays in the output
// register and one more beat is taken into the read stage before in_ch stalls.
module uart_registers_with_rx_fifo
  import urxf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  urxf_in_if.sink     in_ch,
  urxf_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  // Architectural state.
  logic [15:0] char_time_r;
  logic        txrdy_r, txrdy_nxt;
  logic        rxrdy_r, rxrdy_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [15:0] tx_cd_r, tx_cd_nxt;
  logic [15:0] rx_cd_r, rx_cd_nxt;
  fifo_ptr_t   rd_ptr_r, rd_ptr_nxt;
  fifo_ptr_t   wr_ptr_r, wr_ptr_nxt;

  // FIFO memory and its read path.
  logic [7:0]  fifo_mem [FIFO_DEPTH];
  logic [7:0]  mem_rdata_r;
  logic        fwd_r;
  logic [7:0]  fwd_data_r;
  logic        mem_we;
  fifo_idx_t   mem_waddr;
  fifo_idx_t   mem_raddr;
  logic        fwd_nxt;
  logic [7:0]  fifo_q;

  // Read stage.
  logic        s1_valid_r;
  logic [1:0]  s1_mode_r;
  logic [2:0]  s1_addr_r;
  logic [7:0]  s1_data_r;
  logic [15:0] s1_elapsed_r;
  logic        s1_adv;
  logic        in_acc;

  // Output register.
  logic        out_valid_r;
  logic [7:0]  out_rd_r, out_rd_nxt;
  logic        out_irq_r, out_irq_nxt;
  logic        out_txv_r, out_txv_nxt;
  logic [7:0]  out_txb_r, out_txb_nxt;

  // Execute-stage helpers.
  fifo_ptr_t   fifo_cnt;
  logic        fifo_full;
  logic        fifo_empty;
  logic [15:0] load_val;
  logic [15:0] rx_mid;
  logic [7:0]  status_byte;
  logic [7:0]  status_nxt;

  // Handshake: the read stage moves on when the output register is free.
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = out_rd_r;
  assign out_ch.irq       = out_irq_r;
  assign out_ch.tx_valid  = out_txv_r;
  assign out_ch.tx_byte   = out_txb_r;

  // FIFO occupancy from the wrapping pointers.
  assign fifo_cnt   = wr_ptr_r - rd_ptr_r;
  assign fifo_empty = (wr_ptr_r == rd_ptr_r);
  assign fifo_full  = (wr_ptr_r[FIFO_AW] != rd_ptr_r[FIFO_AW]) &&
                      (wr_ptr_r[FIFO_AW-1:0] == rd_ptr_r[FIFO_AW-1:0]);

  // A zero character time loads the timers as one.
  assign load_val = (char_time_r == 16'd0) ? 16'd1 : char_time_r;

  assign status_byte = {5'd0, rxrdy_r, 1'b0, txrdy_r};
  assign fifo_q      = fwd_r ? fwd_data_r : mem_rdata_r;

  // Execute one event against the current state.
  always_comb begin
    txrdy_nxt   = txrdy_r;
    rxrdy_nxt   = rxrdy_r;
    mask_nxt    = mask_r;
    hold_nxt    = hold_r;
    tx_cd_nxt   = tx_cd_r;
    rx_cd_nxt   = rx_cd_r;
    rd_ptr_nxt  = rd_ptr_r;
    wr_ptr_nxt  = wr_ptr_r;
    mem_we      = 1'b0;
    mem_waddr   = wr_ptr_r[FIFO_AW-1:0];
    out_rd_nxt  = 8'd0;
    out_txv_nxt = 1'b0;
    out_txb_nxt = 8'd0;
    rx_mid      = rx_cd_r;
    if (s1_adv) begin
      unique case (s1_mode_r)
        MODE_READ: begin
          if (s1_addr_r == ADDR_DATA) begin
            out_rd_nxt = hold_r;
            rxrdy_nxt  = 1'b0;
          end else if (s1_addr_r == ADDR_STATUS) begin
            out_rd_nxt = status_byte;
          end else begin
            out_rd_nxt = READ_UNMAPPED;
          end
        end
        MODE_WRITE: begin
          if (s1_addr_r == ADDR_DATA) begin
            out_txv_nxt = 1'b1;
            out_txb_nxt = s1_data_r;
            tx_cd_nxt   = load_val;
            txrdy_nxt   = 1'b0;
          end else if (s1_addr_r == ADDR_STATUS) begin
            mask_nxt = s1_data_r;
          end
        end
        MODE_TICK: begin
          // Transmit timer: expiry sets TxRDY.
          if (tx_cd_r != 16'd0) begin
            if (s1_elapsed_r >= tx_cd_r) begin
              tx_cd_nxt = 16'd0;
              txrdy_nxt = 1'b1;
            end else begin
              tx_cd_nxt = tx_cd_r - s1_elapsed_r;
            end
          end
          // Receive timer, then move at most one FIFO byte.
          if (rx_cd_r != 16'd0) begin
            if (s1_elapsed_r >= rx_cd_r) begin
              rx_mid = 16'd0;
            end else begin
              rx_mid = rx_cd_r - s1_elapsed_r;
            end
          end
          rx_cd_nxt = rx_mid;
          if ((rx_mid == 16'd0) && !fifo_empty) begin
            hold_nxt   = fifo_q;
            rd_ptr_nxt = rd_ptr_r + fifo_ptr_t'(1);
            rxrdy_nxt  = 1'b1;
            rx_cd_nxt  = load_val;
          end
        end
        MODE_LINE: begin
          // A byte arriving at a full FIFO is dropped.
          if (!fifo_full) begin
            mem_we     = 1'b1;
            wr_ptr_nxt = wr_ptr_r + fifo_ptr_t'(1);
          end
        end
        default: begin
        end
      endcase
    end
    status_nxt  = {5'd0, rxrdy_nxt, 1'b0, txrdy_nxt};
    out_irq_nxt = |(status_nxt & mask_nxt);
  end

  // The next read uses the pointer after this cycle's event; a same-entry
  // write is forwarded since the memory returns the old contents.
  assign mem_raddr = rd_ptr_nxt[FIFO_AW-1:0];
  assign fwd_nxt   = mem_we && (mem_waddr == mem_raddr);

  // FIFO memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      fifo_mem[mem_waddr] <= s1_data_r;
    end
    if (in_acc) begin
      mem_rdata_r <= fifo_mem[mem_raddr];
      fwd_r       <= fwd_nxt;
      fwd_data_r  <= s1_data_r;
    end
  end

  // Read-stage payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r    <= in_ch.mode;
      s1_addr_r    <= in_ch.addr;
      s1_data_r    <= in_ch.data;
      s1_elapsed_r <= in_ch.elapsed_us;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_rd_r  <= out_rd_nxt;
      out_irq_r <= out_irq_nxt;
      out_txv_r <= out_txv_nxt;
      out_txb_r <= out_txb_nxt;
    end
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      char_time_r <= CHAR_TIME_RESET;
      txrdy_r     <= 1'b1;
      rxrdy_r     <= 1'b0;
      mask_r      <= 8'd0;
      hold_r      <= 8'd0;
      tx_cd_r     <= 16'd0;
      rx_cd_r     <= 16'd0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        char_time_r <= cfg_wdata;
      end
      txrdy_r  <= txrdy_nxt;
      rxrdy_r  <= rxrdy_nxt;
      mask_r   <= mask_nxt;
      hold_r   <= hold_nxt;
      tx_cd_r  <= tx_cd_nxt;
      rx_cd_r  <= rx_cd_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
    end
  end

  // The FIFO never holds more than its depth.
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt <= fifo_ptr_t'(FIFO_DEPTH))
    else $error("FIFO occupancy exceeds depth");

  // An executed event always leaves a result in the output register.
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("executed event produced no result");

  // A pending transmit result implies TxRDY is still clear.
  a_tx_clears_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_txv_r) |-> !txrdy_r)
    else $error("TxRDY set while transmit result pending");

  // RxRDY rises only together with a receive timer restart.
  a_rx_restart: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rxrdy_r) |-> (rx_cd_r != 16'd0))
    else $error("RxRDY set without receive timer restart");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import urxf_pkg::*;

  // Addresses that decode to no register.
  localparam logic [2:0] ADDR_UNMAPPED_LO = 3'd0;
  localparam logic [2:0] ADDR_UNMAPPED_HI = 3'd7;
  localparam int RANDOM_BEATS   = 230;
  localparam int FLOOD_BEATS    = 360;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  addr;
    logic [7:0]  data;
    logic [15:0] elapsed_us;
  } uart_event_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic       tx_valid;
    logic [7:0] tx_byte;
  } uart_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  urxf_in_if  in_ch ();
  urxf_out_if out_ch ();

  uart_registers_with_rx_fifo DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Queues between the stimulus, the driver and the monitor.
  uart_event_t  pending_events[$];
  uart_result_t expected_results[$];

  // Predicted register state of the UART.
  logic [15:0] char_time_q;
  logic [7:0]  status_q;
  logic [7:0]  irq_mask_q;
  logic [7:0]  rx_hold_q;
  logic [15:0] tx_timer_q;
  logic [15:0] rx_timer_q;
  logic [7:0]  rx_fifo_mem [FIFO_DEPTH];
  fifo_ptr_t   rx_rd_ptr;
  fifo_ptr_t   rx_wr_ptr;

  // Run statistics and error counts.
  int queued_beats;
  int checked_beats;
  int sent_bytes;
  int data_reads;
  int dropped_bytes;
  int fifo_peak;
  int settings_run;
  int mismatches;
  int unexpected_beats;

  // Sender burst and receiver stall state.
  int          burst_left;
  int          gap_left;
  logic [5:0]  stall_pos;
  logic [15:0] stall_word;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Timeout: %0d beats still expected", expected_results.size());
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [15:0] timer_reload();
    return (char_time_q == 16'd0) ? 16'd1 : char_time_q;
  endfunction

  function automatic int rx_fifo_level();
    fifo_ptr_t diff;
    diff = rx_wr_ptr - rx_rd_ptr;
    return int'(diff);
  endfunction

  // Advance both character timers; a byte moves into the holding register
  // whenever the receive timer has run out and the FIFO is not empty.
  function automatic void uart_tick(logic [15:0] elapsed);
    if (tx_timer_q != 16'd0) begin
      if (elapsed >= tx_timer_q) begin
        tx_timer_q = 16'd0;
        status_q[ST_TXRDY_BIT] = 1'b1;
      end else begin
        tx_timer_q = tx_timer_q - elapsed;
      end
    end
    if (rx_timer_q != 16'd0) begin
      if (elapsed >= rx_timer_q) rx_timer_q = 16'd0;
      else rx_timer_q = rx_timer_q - elapsed;
    end
    if (rx_timer_q == 16'd0 && rx_fifo_level() != 0) begin
      rx_hold_q = rx_fifo_mem[rx_rd_ptr[FIFO_AW-1:0]];
      rx_rd_ptr = rx_rd_ptr + fifo_ptr_t'(1);
      status_q[ST_RXRDY_BIT] = 1'b1;
      rx_timer_q = timer_reload();
    end
  endfunction

  // Apply one event to the predicted state and return the result beat.
  function automatic uart_result_t uart_apply(uart_event_t ev);
    uart_result_t r;
    r = '0;
    case (ev.mode)
      MODE_READ: begin
        if (ev.addr == ADDR_DATA) begin
          r.read_data = rx_hold_q;
          status_q[ST_RXRDY_BIT] = 1'b0;
          data_reads++;
        end else if (ev.addr == ADDR_STATUS) begin
          r.read_data = status_q;
        end else begin
          r.read_data = READ_UNMAPPED;
        end
      end
      MODE_WRITE: begin
        if (ev.addr == ADDR_DATA) begin
          r.tx_valid = 1'b1;
          r.tx_byte = ev.data;
          tx_timer_q = timer_reload();
          status_q[ST_TXRDY_BIT] = 1'b0;
          sent_bytes++;
        end else if (ev.addr == ADDR_STATUS) begin
          irq_mask_q = ev.data;
        end
      end
      MODE_TICK: uart_tick(ev.elapsed_us);
      MODE_LINE: begin
        if (rx_fifo_level() < FIFO_DEPTH) begin
          rx_fifo_mem[rx_wr_ptr[FIFO_AW-1:0]] = ev.data;
          rx_wr_ptr = rx_wr_ptr + fifo_ptr_t'(1);
          if (rx_fifo_level() > fifo_peak) fifo_peak = rx_fifo_level();
        end else begin
          dropped_bytes++;
        end
      end
      default: ;
    endcase
    r.irq = |(status_q & irq_mask_q);
    return r;
  endfunction

  function automatic void uart_reset_state();
    char_time_q = CHAR_TIME_RESET;
    status_q = 8'h00;
    status_q[ST_TXRDY_BIT] = 1'b1;
    irq_mask_q = 8'h00;
    rx_hold_q = 8'h00;
    tx_timer_q = 16'd0;
    rx_timer_q = 16'd0;
    rx_rd_ptr = '0;
    rx_wr_ptr = '0;
  endfunction

  // Driver: presents pending events in bursts separated by random gaps.
  always @(posedge clk) begin
    uart_event_t ev;
    uart_event_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 4;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        ev.mode = in_ch.mode;
        ev.addr = in_ch.addr;
        ev.data = in_ch.data;
        ev.elapsed_us = in_ch.elapsed_us;
        expected_results.push_back(uart_apply(ev));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_events.size() > 0) begin
          nxt = pending_events.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.mode <= nxt.mode;
          in_ch.addr <= nxt.addr;
          in_ch.data <= nxt.data;
          in_ch.elapsed_us <= nxt.elapsed_us;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat and stalls on a changing pattern.
  always @(posedge clk) begin
    uart_result_t exp_r;
    uart_result_t got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_pos = '0;
      stall_word = '1;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.read_data = out_ch.read_data;
        got.irq = out_ch.irq;
        got.tx_valid = out_ch.tx_valid;
        got.tx_byte = out_ch.tx_byte;
        if (expected_results.size() == 0) begin
          unexpected_beats++;
          if (mismatches + unexpected_beats <= REPORT_LIMIT)
            $display("%0t: unexpected result beat rd=%02h irq=%0b txv=%0b txb=%02h",
                     $time, got.read_data, got.irq, got.tx_valid, got.tx_byte);
        end else begin
          exp_r = expected_results.pop_front();
          checked_beats++;
          if (got.read_data !== exp_r.read_data || got.irq !== exp_r.irq ||
              got.tx_valid !== exp_r.tx_valid || got.tx_byte !== exp_r.tx_byte) begin
            mismatches++;
            if (mismatches + unexpected_beats <= REPORT_LIMIT)
              $display("%0t: beat %0d expected rd=%02h irq=%0b txv=%0b txb=%02h,",
                       $time, checked_beats, exp_r.read_data, exp_r.irq,
                       exp_r.tx_valid, exp_r.tx_byte,
                       " got rd=%02h irq=%0b txv=%0b txb=%02h",
                       got.read_data, got.irq, got.tx_valid, got.tx_byte);
          end
        end
      end
      stall_pos = stall_pos + 6'd1;
      if (stall_pos == '0) begin
        case ($urandom_range(0, 3))
          0: stall_word = '1;
          1: stall_word = 16'($urandom & $urandom);
          default: stall_word = 16'($urandom);
        endcase
      end
      out_ch.ready <= stall_word[stall_pos[3:0]];
    end
  end

  task automatic add_event(input logic [1:0] mode, input logic [2:0] addr,
                           input logic [7:0] data, input logic [15:0] elapsed);
    uart_event_t ev;
    ev.mode = mode;
    ev.addr = addr;
    ev.data = data;
    ev.elapsed_us = elapsed;
    pending_events.push_back(ev);
    queued_beats++;
  endtask

  // Elapsed times clustered around the character time to hit exact expiry.
  function automatic logic [15:0] pick_elapsed();
    int ct;
    int e;
    ct = int'(char_time_q);
    case ($urandom_range(0, 7))
      0: e = 0;
      1: e = (ct > 0) ? ct - 1 : 0;
      2: e = ct;
      3: e = ct + 1;
      4: e = 65535;
      5: e = $urandom_range(0, 65535);
      default: e = $urandom_range(0, 2 * ct + 2);
    endcase
    if (e > 65535) e = 65535;
    return e[15:0];
  endfunction

  // One short software-like sequence, or a fully random item as noise.
  task automatic queue_sequence();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      n = $urandom_range(1, 3);
      repeat (n) add_event(MODE_LINE, 3'($urandom), 8'($urandom), 16'($urandom));
      repeat ($urandom_range(1, 2))
        add_event(MODE_TICK, 3'($urandom), 8'($urandom), pick_elapsed());
      add_event(MODE_READ, ADDR_STATUS, 8'($urandom), 16'($urandom));
      if ($urandom_range(0, 4) != 0)
        add_event(MODE_READ, ADDR_DATA, 8'($urandom), 16'($urandom));
    end else if (kind < 60) begin
      add_event(MODE_WRITE, ADDR_DATA, 8'($urandom), 16'($urandom));
      add_event(MODE_TICK, 3'($urandom), 8'($urandom), pick_elapsed());
      add_event(MODE_READ, ADDR_STATUS, 8'($urandom), 16'($urandom));
    end else if (kind < 70) begin
      case ($urandom_range(0, 3))
        0: add_event(MODE_WRITE, ADDR_STATUS, 8'h04, 16'($urandom));
        1: add_event(MODE_WRITE, ADDR_STATUS, 8'h01, 16'($urandom));
        2: add_event(MODE_WRITE, ADDR_STATUS, 8'h05, 16'($urandom));
        default: add_event(MODE_WRITE, ADDR_STATUS, 8'($urandom), 16'($urandom));
      endcase
    end else if (kind < 80) begin
      add_event(MODE_TICK, 3'($urandom), 8'($urandom), pick_elapsed());
    end else begin
      add_event(2'($urandom), 3'($urandom), 8'($urandom), 16'($urandom));
    end
  endtask

  // Wait until the block has returned every result, then let it settle.
  task automatic wait_until_idle();
    do @(negedge clk);
    while (pending_events.size() != 0 || in_ch.valid || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_char_time(input logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    char_time_q = value;
    settings_run++;
  endtask

  // A phase of random sequences; a flood phase overfills the receive FIFO.
  task automatic run_random_phase(input logic [15:0] char_time, input bit flood);
    int target;
    int start;
    bit flooded;
    write_char_time(char_time);
    start = queued_beats;
    target = flood ? FLOOD_BEATS : RANDOM_BEATS;
    flooded = 1'b0;
    while (queued_beats - start < target) begin
      if (flood && !flooded && queued_beats - start >= 40) begin
        repeat (FIFO_DEPTH + $urandom_range(4, 30))
          add_event(MODE_LINE, 3'($urandom), 8'($urandom), 16'($urandom));
        flooded = 1'b1;
      end
      queue_sequence();
    end
    wait_until_idle();
  endtask

  initial begin
    uart_reset_state();
    queued_beats = 0;
    checked_beats = 0;
    sent_bytes = 0;
    data_reads = 0;
    dropped_bytes = 0;
    fifo_peak = 0;
    settings_run = 1;
    mismatches = 0;
    unexpected_beats = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 16'd0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_READ;
    in_ch.addr = 3'd0;
    in_ch.data = 8'd0;
    in_ch.elapsed_us = 16'd0;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at the reset character time: unmapped addresses, exact
    // timer expiry, idle ticks, an overrun of the holding register and masks.
    add_event(MODE_READ, ADDR_STATUS, 8'h00, 16'd0);
    add_event(MODE_READ, ADDR_DATA, 8'h00, 16'd0);
    add_event(MODE_READ, ADDR_UNMAPPED_LO, 8'h00, 16'd0);
    add_event(MODE_READ, ADDR_UNMAPPED_HI, 8'hff, 16'hffff);
    add_event(MODE_WRITE, ADDR_STATUS, 8'hff, 16'd0);
    add_event(MODE_WRITE, ADDR_UNMAPPED_LO, 8'haa, 16'd0);
    add_event(MODE_WRITE, ADDR_UNMAPPED_HI, 8'h55, 16'd0);
    add_event(MODE_WRITE, ADDR_DATA, 8'h00, 16'd0);
    add_event(MODE_TICK, ADDR_DATA, 8'h00, 16'd0);
    add_event(MODE_TICK, ADDR_DATA, 8'h00, 16'hffff);
    add_event(MODE_WRITE, ADDR_DATA, 8'hff, 16'd0);
    add_event(MODE_TICK, ADDR_DATA, 8'h00, 16'd129);
    add_event(MODE_TICK, ADDR_DATA, 8'h00, 16'd1);
    add_event(MODE_LINE, ADDR_DATA, 8'hff, 16'd0);
    add_event(MODE_LINE, ADDR_DATA, 8'h00, 16'd0);
    add_event(MODE_LINE, ADDR_DATA, 8'h5a, 16'd0);
    add_event(MODE_TICK, ADDR_DATA, 8'h00, 16'd0);
    add_event(MODE_TICK, ADDR_DATA, 8'h00, 16'd0);
    add_event(MODE_TICK, ADDR_DATA, 8'h00, 16'd130);
    add_event(MODE_READ, ADDR_DATA, 8'h00, 16'd0);
    add_event(MODE_READ, ADDR_STATUS, 8'h00, 16'd0);
    add_event(MODE_TICK, ADDR_DATA, 8'h00, 16'hffff);
    add_event(MODE_WRITE, ADDR_STATUS, 8'h04, 16'd0);
    add_event(MODE_WRITE, ADDR_STATUS, 8'hfa, 16'd0);
    add_event(MODE_READ, ADDR_DATA, 8'h00, 16'd0);
    wait_until_idle();

    // Random phases across the character-time range, the extremes included.
    run_random_phase(16'd1, 1'b0);
    run_random_phase(16'd0, 1'b0);
    run_random_phase(16'd65535, 1'b1);
    run_random_phase(CHAR_TIME_RESET, 1'b1);
    run_random_phase(16'($urandom_range(2, 400)), 1'b0);
    run_random_phase(16'($urandom_range(1, 65535)), 1'b0);
    repeat (8) @(posedge clk);

    $display("Covered %0d result beats over %0d character-time settings,",
             checked_beats, settings_run,
             " %0d bytes sent, %0d data reads.", sent_bytes, data_reads);
    $display("Receive FIFO peaked at %0d entries with %0d line bytes dropped while full.",
             fifo_peak, dropped_bytes);
    if (mismatches == 0 && unexpected_beats == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d unexpected beats, %0d results missing",
               mismatches, unexpected_beats, expected_results.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
